>>> src/snpd_pkg.sv
// Snappy decompressor constants: parser states, status and tag codes, tag fields.
package snpd_pkg;
    localparam logic [3:0] S_HDR     = 4'd0;
    localparam logic [3:0] S_TAG     = 4'd1;
    localparam logic [3:0] S_LITLEN  = 4'd2;
    localparam logic [3:0] S_LITDATA = 4'd3;
    localparam logic [3:0] S_OFF     = 4'd4;
    localparam logic [3:0] S_ERR     = 4'd5;
    localparam logic [3:0] S_CHECK   = 4'd6;
    localparam logic [3:0] S_COPY_RD = 4'd7;
    localparam logic [3:0] S_COPY_WR = 4'd8;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_OFFSET = 3'd1;
    localparam logic [2:0] ST_MISMATCH   = 3'd2;
    localparam logic [2:0] ST_TRUNCATED  = 3'd3;
    localparam logic [2:0] ST_BAD_HEADER = 3'd4;

    localparam logic [1:0] TAG_LITERAL = 2'd0;
    localparam logic [1:0] TAG_COPY1   = 2'd1;
    localparam logic [1:0] TAG_COPY2   = 2'd2;

    localparam logic [5:0] LIT_LONG_MIN = 6'd60;
    localparam logic [5:0] LIT_LONG_BIAS = 6'd59;
    localparam logic [7:0] COPY1_HI_MASK = 8'hE0;
endpackage

>>> src/snpd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module snpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/snappy_raw_decompressor_unit.sv
// Raw Snappy stream decompressor with a circular history memory for copies.
//
// Input channel (i_valid/o_ready) carries one compressed byte per request,
// with i_in_last on the final byte of a stream. Output channel
// (o_valid/i_ready) carries one result per request: a data byte
// (o_out_valid = 1) or a status-only result; o_out_last marks the final
// result of the stream, which carries the stream status.
// A result sits in an output register; the next request is taken while a
// result waits, as long as that register is free or being drained.
// Literal bytes and header/tag bytes are taken one per request. A copy
// first checks its offset in S_CHECK, then replays each byte through
// S_COPY_RD (registered history read) and S_COPY_WR (write-back and
// output); no new input is taken until the copy ends.
// A stalled receiver holds the output register and stops the parser.
// Reset returns to the length header; the history memory is not cleared.
// After an error, bytes are dropped until the last byte of the stream.
module snappy_raw_decompressor_unit
    import snpd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 65536
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic       o_out_last,
    output logic [2:0] o_status
);
    localparam int AW = $clog2(HISTORY_DEPTH);

    logic [3:0]    r_state, n_state;
    logic [31:0]   r_prod, n_prod;
    logic [31:0]   r_exp, n_exp;
    logic [4:0]    r_shift, n_shift;
    logic [2:0]    r_err, n_err;
    logic [32:0]   r_pend, n_pend;
    logic [31:0]   r_off, n_off;
    logic [2:0]    r_extra, n_extra;
    logic [6:0]    r_cnt, n_cnt;
    logic          r_last, n_last;
    logic [AW-1:0] r_wp, n_wp;

    logic       r_ov;
    logic [7:0] r_ob;
    logic       r_obv, r_olast;
    logic [2:0] r_ost;

    logic       can_emit, in_acc, in_state, clear;
    logic       emit, e_dv, e_last;
    logic [7:0] e_byte;
    logic [2:0] e_st;
    logic       we;
    logic [7:0] wdata, rdata;
    logic [AW-1:0] raddr, wp_inc;
    logic [AW:0]   off_n, wp_x, rd_x;
    logic [31:0]   off_new, hdr_new, prod_inc;
    logic [1:0]    kind;
    logic [5:0]    top;
    logic          hdr_done, fin, bad_off;

    assign can_emit = !r_ov || i_ready;
    assign in_state = (r_state == S_HDR) || (r_state == S_TAG) || (r_state == S_LITLEN) ||
                      (r_state == S_LITDATA) || (r_state == S_OFF) || (r_state == S_ERR);
    assign o_ready  = can_emit && in_state;
    assign in_acc   = i_valid && o_ready;

    assign off_new  = r_off | (32'(i_in_byte) << {r_shift[4:3], 3'b000});
    assign hdr_new  = r_exp | (32'(i_in_byte[6:0]) << r_shift);
    assign prod_inc = (r_prod == 32'hFFFF_FFFF) ? r_prod : r_prod + 32'd1;
    assign kind     = i_in_byte[1:0];
    assign top      = i_in_byte[7:2];
    assign wp_inc   = (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + AW'(1);
    assign bad_off  = (r_off == 32'd0) || (r_off > r_prod) || (r_off > 32'(HISTORY_DEPTH));

    // Read address wraps around the circular history.
    assign off_n = r_off[AW:0];
    assign wp_x  = {1'b0, r_wp};
    assign rd_x  = (wp_x >= off_n) ? wp_x - off_n
                                   : wp_x + (AW+1)'(HISTORY_DEPTH) - off_n;
    assign raddr = rd_x[AW-1:0];

    always_comb begin
        n_state = r_state;
        n_prod  = r_prod;
        n_exp   = r_exp;
        n_shift = r_shift;
        n_err   = r_err;
        n_pend  = r_pend;
        n_off   = r_off;
        n_extra = r_extra;
        n_cnt   = r_cnt;
        n_last  = r_last;
        n_wp    = r_wp;
        emit    = 1'b0;
        e_byte  = 8'd0;
        e_dv    = 1'b0;
        e_last  = 1'b0;
        e_st    = ST_OK;
        we      = 1'b0;
        wdata   = i_in_byte;
        clear   = 1'b0;
        hdr_done = 1'b0;
        fin     = 1'b0;
        unique case (r_state)
            S_ERR: begin
                if (in_acc && i_in_last) begin
                    emit   = 1'b1;
                    e_last = 1'b1;
                    e_st   = r_err;
                    clear  = 1'b1;
                end
            end
            S_HDR: begin
                if (in_acc) begin
                    if (r_shift == 5'd28 && i_in_byte >= 8'd16) begin
                        emit   = 1'b1;
                        e_last = i_in_last;
                        e_st   = ST_BAD_HEADER;
                        n_err  = ST_BAD_HEADER;
                        n_state = S_ERR;
                        clear  = i_in_last;
                    end else begin
                        n_exp = hdr_new;
                        if (r_shift == 5'd28 || !i_in_byte[7]) begin
                            hdr_done = 1'b1;
                            n_state  = S_TAG;
                            n_shift  = 5'd0;
                        end else begin
                            n_shift = r_shift + 5'd7;
                        end
                        if (i_in_last) begin
                            emit   = 1'b1;
                            e_last = 1'b1;
                            e_st   = !hdr_done ? ST_TRUNCATED :
                                     (hdr_new != 32'd0) ? ST_MISMATCH : ST_OK;
                            clear  = 1'b1;
                        end
                    end
                end
            end
            S_TAG: begin
                if (in_acc) begin
                    n_shift = 5'd0;
                    n_off   = 32'd0;
                    if (kind == TAG_LITERAL) begin
                        if (top < LIT_LONG_MIN) begin
                            n_pend  = 33'(top) + 33'd1;
                            n_state = S_LITDATA;
                        end else begin
                            n_extra = 3'(top - LIT_LONG_BIAS);
                            n_state = S_LITLEN;
                        end
                    end else if (kind == TAG_COPY1) begin
                        n_pend  = 33'd4 + 33'(top[2:0]);
                        n_off   = 32'(i_in_byte & COPY1_HI_MASK) << 3;
                        n_extra = 3'd1;
                        n_state = S_OFF;
                    end else begin
                        n_pend  = 33'(top) + 33'd1;
                        n_extra = (kind == TAG_COPY2) ? 3'd2 : 3'd4;
                        n_state = S_OFF;
                    end
                    if (i_in_last) begin
                        emit   = 1'b1;
                        e_last = 1'b1;
                        e_st   = ST_TRUNCATED;
                        clear  = 1'b1;
                    end
                end
            end
            S_LITLEN: begin
                if (in_acc) begin
                    n_off   = off_new;
                    n_shift = r_shift + 5'd8;
                    n_extra = r_extra - 3'd1;
                    if (r_extra == 3'd1) begin
                        n_pend  = {1'b0, off_new} + 33'd1;
                        n_state = S_LITDATA;
                    end
                    if (i_in_last) begin
                        emit   = 1'b1;
                        e_last = 1'b1;
                        e_st   = ST_TRUNCATED;
                        clear  = 1'b1;
                    end
                end
            end
            S_LITDATA: begin
                if (in_acc) begin
                    we     = 1'b1;
                    emit   = 1'b1;
                    e_byte = i_in_byte;
                    e_dv   = 1'b1;
                    n_prod = prod_inc;
                    n_wp   = wp_inc;
                    n_pend = r_pend - 33'd1;
                    fin    = (r_pend == 33'd1);
                    if (fin) begin
                        n_state = S_TAG;
                    end
                    if (i_in_last) begin
                        e_last = 1'b1;
                        e_st   = !fin ? ST_TRUNCATED :
                                 (prod_inc != r_exp) ? ST_MISMATCH : ST_OK;
                        clear  = 1'b1;
                    end
                end
            end
            S_OFF: begin
                if (in_acc) begin
                    n_off   = off_new;
                    n_shift = r_shift + 5'd8;
                    n_extra = r_extra - 3'd1;
                    if (r_extra == 3'd1) begin
                        n_state = S_CHECK;
                        n_last  = i_in_last;
                    end else if (i_in_last) begin
                        emit   = 1'b1;
                        e_last = 1'b1;
                        e_st   = ST_TRUNCATED;
                        clear  = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (bad_off) begin
                    if (can_emit) begin
                        emit    = 1'b1;
                        e_last  = r_last;
                        e_st    = ST_BAD_OFFSET;
                        n_err   = ST_BAD_OFFSET;
                        n_state = S_ERR;
                        clear   = r_last;
                    end
                end else begin
                    n_cnt   = r_pend[6:0];
                    n_state = S_COPY_RD;
                end
            end
            S_COPY_RD: begin
                n_state = S_COPY_WR;
            end
            S_COPY_WR: begin
                if (can_emit) begin
                    we     = 1'b1;
                    wdata  = rdata;
                    emit   = 1'b1;
                    e_byte = rdata;
                    e_dv   = 1'b1;
                    n_prod = prod_inc;
                    n_wp   = wp_inc;
                    n_cnt  = r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        n_pend  = 33'd0;
                        n_state = S_TAG;
                        if (r_last) begin
                            e_last = 1'b1;
                            e_st   = (prod_inc != r_exp) ? ST_MISMATCH : ST_OK;
                            clear  = 1'b1;
                        end
                    end else begin
                        // Next byte is read only after this write lands, so
                        // overlapping copies see their own output.
                        n_state = S_COPY_RD;
                    end
                end
            end
            default: begin
                n_state = S_HDR;
            end
        endcase
        if (clear) begin
            n_state = S_HDR;
            n_prod  = 32'd0;
            n_exp   = 32'd0;
            n_shift = 5'd0;
            n_err   = ST_OK;
            n_pend  = 33'd0;
            n_off   = 32'd0;
            n_extra = 3'd0;
            n_last  = 1'b0;
            n_wp    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HDR;
            r_prod  <= 32'd0;
            r_exp   <= 32'd0;
            r_shift <= 5'd0;
            r_err   <= ST_OK;
            r_pend  <= 33'd0;
            r_off   <= 32'd0;
            r_extra <= 3'd0;
            r_cnt   <= 7'd0;
            r_last  <= 1'b0;
            r_wp    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prod  <= n_prod;
            r_exp   <= n_exp;
            r_shift <= n_shift;
            r_err   <= n_err;
            r_pend  <= n_pend;
            r_off   <= n_off;
            r_extra <= n_extra;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
            r_wp    <= n_wp;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ob    <= e_byte;
            r_obv   <= e_dv;
            r_olast <= e_last;
            r_ost   <= e_st;
        end
    end

    snpd_ram #(
        .WIDTH(8),
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_wp),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_valid     = r_ov;
    assign o_out_byte  = r_ob;
    assign o_out_valid = r_obv;
    assign o_out_last  = r_olast;
    assign o_status    = r_ost;
endmodule
